// ===== rtl/core/jtl_pkg.sv =====
// jtl_pkg: types, character codes and sizes shared by the json token lexer
// no dependencies; every rtl/core file refers to it by scoped names
`default_nettype none

package jtl_pkg;

  // width of the internal line counter, 8 to 32
  localparam int LINE_BITS = 24;
  localparam int LINE_OUT_BITS = 24;

  // most results a single input item can cause
  localparam int MAX_RES = 5;
  localparam int RES_CNT_BITS = $clog2(MAX_RES + 1);

  // depth of the queue between front and back
  localparam int BQ_DEPTH = 4;
  localparam int BQ_AW = $clog2(BQ_DEPTH);
  localparam int BQ_CW = $clog2(BQ_DEPTH + 1);

  // depth of the result queue on the output side
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW = $clog2(OQ_DEPTH);
  localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

  // utf-8 encoding constants
  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF8_CONT      = 8'h80;
  localparam logic [7:0]  UTF8_MASK      = 8'h3F;

  // character codes
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_QUOTE      = 8'd34;
  localparam logic [7:0] CH_PLUS       = 8'd43;
  localparam logic [7:0] CH_MINUS      = 8'd45;
  localparam logic [7:0] CH_DOT        = 8'd46;
  localparam logic [7:0] CH_EXP_UP     = 8'd69;
  localparam logic [7:0] CH_BSLASH     = 8'd92;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;
  localparam logic [7:0] CH_EXP_LO     = 8'd101;
  localparam logic [7:0] CH_U          = 8'd117;

  typedef enum logic [2:0] {
    KIND_STR   = 3'd0,
    KIND_IDENT = 3'd1,
    KIND_NUM   = 3'd2,
    KIND_CHAR  = 3'd3,
    KIND_END   = 3'd4
  } kind_t;

  typedef enum logic [9:0] {
    M_IDLE  = 10'b00_0000_0001,
    M_STR   = 10'b00_0000_0010,
    M_ESC   = 10'b00_0000_0100,
    M_HEX   = 10'b00_0000_1000,
    M_IDENT = 10'b00_0001_0000,
    M_MINUS = 10'b00_0010_0000,
    M_INT   = 10'b00_0100_0000,
    M_FRAC  = 10'b00_1000_0000,
    M_EXPS  = 10'b01_0000_0000,
    M_EXPD  = 10'b10_0000_0000
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t                    token_kind;
    logic                     has_byte;
    logic [7:0]               out_byte;
    logic                     last_of_token;
    logic [LINE_OUT_BITS-1:0] line_number;
  } out_item_t;

  // one result without its line number
  typedef struct packed {
    kind_t      kind;
    logic       has_byte;
    logic [7:0] tok_byte;
    logic       last;
  } tok_t;

  // all results of one input item
  typedef struct packed {
    tok_t [MAX_RES-1:0]       slot;
    logic [RES_CNT_BITS-1:0]  cnt;
    logic [LINE_OUT_BITS-1:0] line;
  } bundle_t;

endpackage

`default_nettype wire

// ===== rtl/core/jtl_front.sv =====
// jtl_front: lexer state machine and line counter, one input item per cycle while take_item is high
// turns each item into a bundle of results; uses jtl_pkg
`default_nettype none

module jtl_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take_item,
  input  wire jtl_pkg::in_item_t item,
  output logic                   bundle_valid,
  output jtl_pkg::bundle_t       bundle
);

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  jtl_pkg::mode_t                  mode_r, mode_nxt;
  logic [15:0]                     acc_r, acc_nxt;
  logic [2:0]                      hcnt_r, hcnt_nxt;
  logic [jtl_pkg::LINE_BITS-1:0]   line_r, line_nxt;
  jtl_pkg::bundle_t                bd;
  logic [31:0]                     line_ext;

  function automatic logic is_space(input logic [7:0] c);
    return c == jtl_pkg::CH_SPACE || (c >= jtl_pkg::CH_TAB && c <= jtl_pkg::CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic hex_t hex_of(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (is_digit(c)) h.value = 4'(c - 8'd48);
    else if (c >= 8'd97 && c <= 8'd102) h.value = 4'(c - 8'd87);
    else if (c >= 8'd65 && c <= 8'd70) h.value = 4'(c - 8'd55);
    else h.valid = 1'b0;
    return h;
  endfunction

  function automatic jtl_pkg::bundle_t push_tok(input jtl_pkg::bundle_t b,
                                                input jtl_pkg::kind_t k,
                                                input logic has,
                                                input logic [7:0] v,
                                                input logic last);
    jtl_pkg::bundle_t r;
    r = b;
    r.slot[r.cnt] = '{kind: k, has_byte: has, tok_byte: has ? v : 8'd0, last: last};
    r.cnt = r.cnt + 1'b1;
    return r;
  endfunction

  function automatic jtl_pkg::bundle_t push_utf8(input jtl_pkg::bundle_t b,
                                                 input logic [15:0] h);
    jtl_pkg::bundle_t r;
    r = b;
    if (h < jtl_pkg::UTF8_ONE_LIMIT) begin
      r = push_tok(r, jtl_pkg::KIND_STR, 1'b1, h[7:0], 1'b0);
    end else if (h < jtl_pkg::UTF8_TWO_LIMIT) begin
      r = push_tok(r, jtl_pkg::KIND_STR, 1'b1, jtl_pkg::UTF8_LEAD2 | 8'(h >> 6), 1'b0);
      r = push_tok(r, jtl_pkg::KIND_STR, 1'b1,
                   jtl_pkg::UTF8_CONT | (jtl_pkg::UTF8_MASK & h[7:0]), 1'b0);
    end else begin
      r = push_tok(r, jtl_pkg::KIND_STR, 1'b1, jtl_pkg::UTF8_LEAD3 | 8'(h >> 12), 1'b0);
      r = push_tok(r, jtl_pkg::KIND_STR, 1'b1,
                   jtl_pkg::UTF8_CONT | (jtl_pkg::UTF8_MASK & 8'(h >> 6)), 1'b0);
      r = push_tok(r, jtl_pkg::KIND_STR, 1'b1,
                   jtl_pkg::UTF8_CONT | (jtl_pkg::UTF8_MASK & h[7:0]), 1'b0);
    end
    return r;
  endfunction

  always_comb begin
    logic       go;
    logic [7:0] b;
    hex_t       hv;
    logic [15:0] acc_sh;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    hcnt_nxt = hcnt_r;
    line_nxt = line_r;
    bd       = '0;
    b        = item.in_byte;
    hv       = hex_of(b);
    acc_sh   = {acc_r[11:0], hv.value};
    go       = 1'b1;
    if (item.end_of_input) begin
      unique case (mode_r)
        jtl_pkg::M_HEX: begin
          bd = push_utf8(bd, acc_r);
          bd = push_tok(bd, jtl_pkg::KIND_STR, 1'b0, 8'd0, 1'b1);
        end
        jtl_pkg::M_STR, jtl_pkg::M_ESC:
          bd = push_tok(bd, jtl_pkg::KIND_STR, 1'b0, 8'd0, 1'b1);
        jtl_pkg::M_IDENT:
          bd = push_tok(bd, jtl_pkg::KIND_IDENT, 1'b0, 8'd0, 1'b1);
        jtl_pkg::M_MINUS: begin
          bd = push_tok(bd, jtl_pkg::KIND_CHAR, 1'b1, jtl_pkg::CH_MINUS, 1'b0);
          bd = push_tok(bd, jtl_pkg::KIND_CHAR, 1'b0, 8'd0, 1'b1);
        end
        jtl_pkg::M_INT, jtl_pkg::M_FRAC, jtl_pkg::M_EXPS, jtl_pkg::M_EXPD:
          bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b0, 8'd0, 1'b1);
        default: ;
      endcase
      bd       = push_tok(bd, jtl_pkg::KIND_END, 1'b0, 8'd0, 1'b1);
      mode_nxt = jtl_pkg::M_IDLE;
      acc_nxt  = 16'd0;
      hcnt_nxt = 3'd0;
    end else begin
      if (b == jtl_pkg::CH_LF && line_r != {jtl_pkg::LINE_BITS{1'b1}}) begin
        line_nxt = line_r + 1'b1;
      end
      // a byte that ends a token is seen again in the new mode, at most twice in all
      for (int p = 0; p < 2; p++) begin
        if (go) begin
          go = 1'b0;
          unique case (mode_nxt)
            jtl_pkg::M_IDLE: begin
              priority if (is_space(b)) begin
              end else if (b == jtl_pkg::CH_QUOTE) begin
                mode_nxt = jtl_pkg::M_STR;
              end else if (is_alpha(b)) begin
                bd = push_tok(bd, jtl_pkg::KIND_IDENT, 1'b1, b, 1'b0);
                mode_nxt = jtl_pkg::M_IDENT;
              end else if (is_digit(b)) begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b1, b, 1'b0);
                mode_nxt = jtl_pkg::M_INT;
              end else if (b == jtl_pkg::CH_MINUS) begin
                mode_nxt = jtl_pkg::M_MINUS;
              end else begin
                bd = push_tok(bd, jtl_pkg::KIND_CHAR, 1'b1, b, 1'b0);
                bd = push_tok(bd, jtl_pkg::KIND_CHAR, 1'b0, 8'd0, 1'b1);
              end
            end
            jtl_pkg::M_STR: begin
              priority if (b == jtl_pkg::CH_QUOTE) begin
                bd = push_tok(bd, jtl_pkg::KIND_STR, 1'b0, 8'd0, 1'b1);
                mode_nxt = jtl_pkg::M_IDLE;
              end else if (b == jtl_pkg::CH_BSLASH) begin
                mode_nxt = jtl_pkg::M_ESC;
              end else begin
                bd = push_tok(bd, jtl_pkg::KIND_STR, 1'b1, b, 1'b0);
              end
            end
            jtl_pkg::M_ESC: begin
              if (b == jtl_pkg::CH_U) begin
                acc_nxt  = 16'd0;
                hcnt_nxt = 3'd0;
                mode_nxt = jtl_pkg::M_HEX;
              end else begin
                bd = push_tok(bd, jtl_pkg::KIND_STR, 1'b1, b, 1'b0);
                mode_nxt = jtl_pkg::M_STR;
              end
            end
            jtl_pkg::M_HEX: begin
              if (hv.valid) begin
                // fourth digit completes the escape
                if (hcnt_r >= 3'd3) begin
                  bd = push_utf8(bd, acc_sh);
                  acc_nxt  = 16'd0;
                  hcnt_nxt = 3'd0;
                  mode_nxt = jtl_pkg::M_STR;
                end else begin
                  acc_nxt  = acc_sh;
                  hcnt_nxt = hcnt_r + 3'd1;
                end
              end else begin
                // short escape: flush the value, byte is seen again in string mode
                bd = push_utf8(bd, acc_r);
                acc_nxt  = 16'd0;
                hcnt_nxt = 3'd0;
                mode_nxt = jtl_pkg::M_STR;
                go = 1'b1;
              end
            end
            jtl_pkg::M_IDENT: begin
              if (is_alpha(b) || is_digit(b) || b == jtl_pkg::CH_UNDERSCORE) begin
                bd = push_tok(bd, jtl_pkg::KIND_IDENT, 1'b1, b, 1'b0);
              end else begin
                bd = push_tok(bd, jtl_pkg::KIND_IDENT, 1'b0, 8'd0, 1'b1);
                mode_nxt = jtl_pkg::M_IDLE;
                go = 1'b1;
              end
            end
            jtl_pkg::M_MINUS: begin
              if (is_digit(b)) begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b1, jtl_pkg::CH_MINUS, 1'b0);
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b1, b, 1'b0);
                mode_nxt = jtl_pkg::M_INT;
              end else begin
                bd = push_tok(bd, jtl_pkg::KIND_CHAR, 1'b1, jtl_pkg::CH_MINUS, 1'b0);
                bd = push_tok(bd, jtl_pkg::KIND_CHAR, 1'b0, 8'd0, 1'b1);
                mode_nxt = jtl_pkg::M_IDLE;
                go = 1'b1;
              end
            end
            jtl_pkg::M_INT, jtl_pkg::M_FRAC: begin
              priority if (is_digit(b)) begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b1, b, 1'b0);
              end else if (b == jtl_pkg::CH_DOT && mode_nxt == jtl_pkg::M_INT) begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b1, b, 1'b0);
                mode_nxt = jtl_pkg::M_FRAC;
              end else if (b == jtl_pkg::CH_EXP_LO || b == jtl_pkg::CH_EXP_UP) begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b1, b, 1'b0);
                mode_nxt = jtl_pkg::M_EXPS;
              end else begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b0, 8'd0, 1'b1);
                mode_nxt = jtl_pkg::M_IDLE;
                go = 1'b1;
              end
            end
            jtl_pkg::M_EXPS: begin
              if (b == jtl_pkg::CH_PLUS || b == jtl_pkg::CH_MINUS || is_digit(b)) begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b1, b, 1'b0);
                mode_nxt = jtl_pkg::M_EXPD;
              end else begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b0, 8'd0, 1'b1);
                mode_nxt = jtl_pkg::M_IDLE;
                go = 1'b1;
              end
            end
            jtl_pkg::M_EXPD: begin
              if (is_digit(b)) begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b1, b, 1'b0);
              end else begin
                bd = push_tok(bd, jtl_pkg::KIND_NUM, 1'b0, 8'd0, 1'b1);
                mode_nxt = jtl_pkg::M_IDLE;
                go = 1'b1;
              end
            end
            default: begin
              mode_nxt = jtl_pkg::M_IDLE;
              go = 1'b1;
            end
          endcase
        end
      end
    end
  end

  assign line_ext     = 32'(line_nxt);
  assign bundle_valid = take_item && (bd.cnt != '0);

  always_comb begin
    bundle      = bd;
    bundle.line = line_ext[jtl_pkg::LINE_OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jtl_pkg::M_IDLE;
      acc_r  <= 16'd0;
      hcnt_r <= 3'd0;
      line_r <= {{(jtl_pkg::LINE_BITS-1){1'b0}}, 1'b1};
    end else if (take_item) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      hcnt_r <= hcnt_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/jtl_bundle_fifo.sv =====
// jtl_bundle_fifo: short queue of result bundles between front and back
// uses jtl_pkg for the bundle type and depth
`default_nettype none

module jtl_bundle_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire jtl_pkg::bundle_t wr_data,
  output logic                  q_full,
  input  wire logic             rd_en,
  output logic                  q_empty,
  output jtl_pkg::bundle_t      rd_data
);

  jtl_pkg::bundle_t               mem_r [jtl_pkg::BQ_DEPTH];
  logic [jtl_pkg::BQ_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [jtl_pkg::BQ_CW-1:0]      cnt_r, cnt_nxt;
  logic                           do_wr, do_rd;

  assign q_full  = cnt_r == jtl_pkg::BQ_CW'(jtl_pkg::BQ_DEPTH);
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == jtl_pkg::BQ_AW'(jtl_pkg::BQ_DEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == jtl_pkg::BQ_AW'(jtl_pkg::BQ_DEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/jtl_back.sv =====
// jtl_back: walks the head bundle one result a cycle, while the output queue has room, into a small output queue
// uses jtl_pkg for the bundle and result types
`default_nettype none

module jtl_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               bq_empty,
  input  wire jtl_pkg::bundle_t   head,
  output logic                    bq_pop,
  output logic                    empty,
  input  wire logic               pop,
  output jtl_pkg::out_item_t      out_data
);

  logic [jtl_pkg::RES_CNT_BITS-1:0] idx_r;
  jtl_pkg::out_item_t               oq_r [jtl_pkg::OQ_DEPTH];
  logic [jtl_pkg::OQ_AW-1:0]        oq_wr_r, oq_rd_r;
  logic [jtl_pkg::OQ_CW-1:0]        oq_cnt_r;
  logic                             oq_full, oq_push, oq_pop, last_slot;
  jtl_pkg::tok_t                    cur;
  jtl_pkg::out_item_t               cur_item;

  assign oq_full   = oq_cnt_r == jtl_pkg::OQ_CW'(jtl_pkg::OQ_DEPTH);
  assign empty     = oq_cnt_r == '0;
  assign oq_push   = !bq_empty && !oq_full;
  assign oq_pop    = pop && !empty;
  assign cur       = head.slot[idx_r];
  assign last_slot = idx_r == head.cnt - 1'b1;
  assign bq_pop    = oq_push && last_slot;
  assign out_data  = oq_r[oq_rd_r];

  assign cur_item = '{token_kind:    cur.kind,
                      has_byte:      cur.has_byte,
                      out_byte:      cur.tok_byte,
                      last_of_token: cur.last,
                      line_number:   head.line};

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[oq_wr_r] <= cur_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        idx_r   <= last_slot ? '0 : idx_r + 1'b1;
        oq_wr_r <= (oq_wr_r == jtl_pkg::OQ_AW'(jtl_pkg::OQ_DEPTH - 1)) ? '0 : oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= (oq_rd_r == jtl_pkg::OQ_AW'(jtl_pkg::OQ_DEPTH - 1)) ? '0 : oq_rd_r + 1'b1;
      end
      if (oq_push && !oq_pop) oq_cnt_r <= oq_cnt_r + 1'b1;
      else if (oq_pop && !oq_push) oq_cnt_r <= oq_cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/json_token_lexer_unit.sv =====
// json_token_lexer_unit: top level of the streaming json token lexer
// instantiates jtl_front, jtl_bundle_fifo and jtl_back; uses jtl_pkg
`default_nettype none

// Streaming JSON lexer: push one byte (or an end-of-input marker) per cycle and
// pop token bytes, closing items and end items from a queue-style output. The
// front lexer state machine takes one item every cycle while its four-entry
// bundle queue has room; each item yields zero to five results, and the back
// end delivers one result per cycle while its output queue has room, so the
// results of an item leave the back end one after another and the bundle queue
// absorbs bursts. A result is written into the bundle queue on the edge that
// accepts its item and later into the output queue, from which it is popped.
// There is no clearing pass: the block takes items as soon as reset is released.
module json_token_lexer_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire jtl_pkg::in_item_t  in_data,
  output logic                    empty,
  input  wire logic               pop,
  output jtl_pkg::out_item_t      out_data
);

  logic             take_item, bundle_valid, bq_full, bq_empty, bq_pop;
  jtl_pkg::bundle_t bundle, head;

  assign full      = bq_full;
  assign take_item = push && !bq_full;

  jtl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take_item    (take_item),
    .item         (in_data),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  jtl_bundle_fifo u_bq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bundle_valid),
    .wr_data (bundle),
    .q_full  (bq_full),
    .rd_en   (bq_pop),
    .q_empty (bq_empty),
    .rd_data (head)
  );

  jtl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .bq_empty (bq_empty),
    .head     (head),
    .bq_pop   (bq_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
